FILE: design/direct_mapped_icache_stats_macros.svh
// Assertion macros used by the cache statistics top-level RTL file.
`ifndef DIRECT_MAPPED_ICACHE_STATS_MACROS_SVH
`define DIRECT_MAPPED_ICACHE_STATS_MACROS_SVH

// Check cons in the same cycle as ante.
`define DMIC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Check cons in the cycle after ante.
`define DMIC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/dmic_pkg.sv
// Types and constants of the direct-mapped instruction cache statistics block.
`default_nettype none
package dmic_pkg;

    localparam int ADDR_W     = 32;
    localparam int LINES      = 16;
    localparam int LINE_BYTES = 4;
    localparam int OFFSET_W   = $clog2(LINE_BYTES);
    localparam int INDEX_W    = $clog2(LINES);
    localparam int TAG_W      = ADDR_W - OFFSET_W - INDEX_W;
    localparam int COST_W     = 11;
    localparam int CNT_W      = 32;
    localparam int CYC_W      = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [7:0] ACCESS_TIME_RST  = 8'd1;
    localparam logic [9:0] MISS_PENALTY_RST = 10'd10;

    typedef logic [INDEX_W-1:0] t_index;
    typedef logic [TAG_W-1:0]   t_tag;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRAM_BASE    = 3'd0,
        CFG_SRAM_LENGTH  = 3'd1,
        CFG_BYPASS_SRAM  = 3'd2,
        CFG_ACCESS_TIME  = 3'd3,
        CFG_MISS_PENALTY = 3'd4,
        CFG_SRAM_EXTRA   = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
    } t_fetch;

    typedef struct packed {
        logic              hit;
        logic              in_sram;
        logic [COST_W-1:0] access_cost;
        logic [CNT_W-1:0]  total_accesses;
        logic [CNT_W-1:0]  total_hits;
        logic [CNT_W-1:0]  total_misses;
        logic [CNT_W-1:0]  total_sram;
        logic [CYC_W-1:0]  total_cycles;
    } t_result;

    typedef struct packed {
        logic   lookup;
        t_index index;
        t_tag   tag;
    } t_tag_req;

endpackage
`default_nettype wire

FILE: design/dmic_stream_if.sv
// Valid/ready channel carrying one item of a given payload type.
`default_nettype none
interface dmic_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: design/dmic_tag_store.sv
// Direct-mapped tag store with per-line valid bits, lookup and fill on miss.
`default_nettype none
module dmic_tag_store
    import dmic_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_tag_req i_req,
    output logic          o_hit
);

    logic [LINES-1:0] r_valid;
    t_tag             r_tag [LINES];

    assign o_hit = i_req.lookup && r_valid[i_req.index] && (r_tag[i_req.index] == i_req.tag);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_req.lookup && !o_hit) begin
            r_valid[i_req.index] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.lookup && !o_hit) begin
            r_tag[i_req.index] <= i_req.tag;
        end
    end

endmodule
`default_nettype wire

FILE: design/direct_mapped_icache_stats.sv
// Top level: direct-mapped instruction cache model with access statistics.
//
// i_fetch carries one fetch byte address per item; o_result returns one item
// per fetch with hit, SRAM window flag, this access's cost and the running
// counters after the access. Both channels are valid/ready; an item moves on
// an edge where both are high.
// An accepted fetch loads the input register; once the result register can
// advance, the item loads the result register and o_result.valid rises after it.
// Throughput: one item per cycle while the result is not stalled, as the tag
// lookup and fill happen between the input register and the result register.
// The window check is done as the address is registered; lookup, fill, cost
// and counter updates are done as the result register loads.
// A stalled result holds in the result register while one more fetch waits
// in the input register; i_fetch.ready then drops until o_result.ready rises.
// The configuration port writes one register per edge with i_cfg_we high;
// write it only when no item is in flight.
// Reset (i_rst_n low, synchronous) clears all line valid bits, all counters
// and the valid flags of both pipeline registers, and loads the register reset values.
`default_nettype none
module direct_mapped_icache_stats
    import dmic_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    dmic_stream_if.sink                i_fetch,
    dmic_stream_if.source              o_result
);

`include "direct_mapped_icache_stats_macros.svh"

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + CNT_W'(1);
    endfunction

    logic [ADDR_W-1:0] r_sram_base;
    logic [ADDR_W-1:0] r_sram_length;
    logic              r_bypass;
    logic [7:0]        r_access_time;
    logic [9:0]        r_miss_penalty;
    logic [7:0]        r_sram_extra;

    logic              r_in_valid;
    logic [ADDR_W-1:0] r_addr;
    logic              r_in_win;

    logic              r_out_valid;
    t_result           r_res;

    logic [CNT_W-1:0]  r_accesses;
    logic [CNT_W-1:0]  r_hits;
    logic [CNT_W-1:0]  r_misses;
    logic [CNT_W-1:0]  r_sram;
    logic [CYC_W-1:0]  r_cycles;

    logic              advance;
    logic              fire;
    logic              accept;
    logic              win_now;
    logic              bypassed;
    logic              hit;
    t_tag_req          tag_req;
    t_result           n_res;
    logic [COST_W-1:0] cost;
    logic [CYC_W:0]    cyc_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sram_base    <= '0;
            r_sram_length  <= '0;
            r_bypass       <= 1'b0;
            r_access_time  <= ACCESS_TIME_RST;
            r_miss_penalty <= MISS_PENALTY_RST;
            r_sram_extra   <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_SRAM_BASE:    r_sram_base    <= i_cfg_data[ADDR_W-1:0];
                CFG_SRAM_LENGTH:  r_sram_length  <= i_cfg_data[ADDR_W-1:0];
                CFG_BYPASS_SRAM:  r_bypass       <= i_cfg_data[0];
                CFG_ACCESS_TIME:  r_access_time  <= i_cfg_data[7:0];
                CFG_MISS_PENALTY: r_miss_penalty <= i_cfg_data[9:0];
                CFG_SRAM_EXTRA:   r_sram_extra   <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign advance         = !r_out_valid || o_result.ready;
    assign fire            = r_in_valid && advance;
    assign i_fetch.ready   = !r_in_valid || advance;
    assign accept          = i_fetch.valid && i_fetch.ready;

    assign win_now = (i_fetch.data.address >= r_sram_base) &&
                     ({1'b0, i_fetch.data.address} <
                      ({1'b0, r_sram_base} + {1'b0, r_sram_length}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_fetch.ready) begin
            r_in_valid <= i_fetch.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_addr   <= i_fetch.data.address;
            r_in_win <= win_now;
        end
    end

    assign bypassed       = r_in_win && r_bypass;
    assign tag_req.lookup = fire && !bypassed;
    assign tag_req.index  = r_addr[OFFSET_W +: INDEX_W];
    assign tag_req.tag    = r_addr[ADDR_W-1 -: TAG_W];

    dmic_tag_store u_tag_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (tag_req),
        .o_hit   (hit)
    );

    always_comb begin
        cost = COST_W'(r_access_time);
        if (!hit && !bypassed) begin
            cost = cost + COST_W'(r_miss_penalty);
        end
        if (r_in_win) begin
            cost = cost + COST_W'(r_sram_extra);
        end
        cyc_sum = {1'b0, r_cycles} + (CYC_W+1)'(cost);

        n_res.hit            = hit;
        n_res.in_sram        = r_in_win;
        n_res.access_cost    = cost;
        n_res.total_accesses = sat_inc(r_accesses);
        n_res.total_hits     = hit ? sat_inc(r_hits) : r_hits;
        n_res.total_misses   = hit ? r_misses : sat_inc(r_misses);
        n_res.total_sram     = r_in_win ? sat_inc(r_sram) : r_sram;
        n_res.total_cycles   = cyc_sum[CYC_W] ? '1 : cyc_sum[CYC_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accesses  <= '0;
            r_hits      <= '0;
            r_misses    <= '0;
            r_sram      <= '0;
            r_cycles    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_accesses <= n_res.total_accesses;
                r_hits     <= n_res.total_hits;
                r_misses   <= n_res.total_misses;
                r_sram     <= n_res.total_sram;
                r_cycles   <= n_res.total_cycles;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_res <= n_res;
        end
    end

    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_res;

    `DMIC_ASSERT_NOW(a_hit_counted, r_out_valid && r_res.hit, r_res.total_hits != '0, "hit not counted")
    `DMIC_ASSERT_NOW(a_miss_counted, r_out_valid && !r_res.hit, r_res.total_misses != '0, "miss not counted")
    `DMIC_ASSERT_NOW(a_sram_counted, r_out_valid && r_res.in_sram, r_res.total_sram != '0, "sram access not counted")
    `DMIC_ASSERT_NOW(a_stall_full, !i_fetch.ready, r_in_valid && r_out_valid && !o_result.ready, "input stalled with room")
    `DMIC_ASSERT_NEXT(a_fire_result, fire, r_out_valid, "processed item produced no result")

endmodule
`default_nettype wire
